[hdl/lrucache_pkg.sv]
// Shared types, constants and helpers for the LRU set-associative cache model.
package lrucache_pkg;

  localparam int ADDR_W     = 64;
  localparam int CMD_W      = 2;
  localparam int OUTCOME_W  = 2;
  localparam int CNT_W      = 32;
  localparam int SIB_W      = 3;
  localparam int WAYS_W     = 4;
  localparam int OFF_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int WAY_IDX_W  = 4;

  localparam int S_TDATA_W  = 64;
  localparam int OUT_BITS   = OUTCOME_W + 1 + 3 * CNT_W;
  localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

  localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_FETCH,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] hit_way;
    logic                 free;
    logic [WAY_IDX_W-1:0] free_way;
    logic [WAY_IDX_W-1:0] victim_way;
  } scan_res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

[hdl/lrucache_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lrucache_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/lrucache_decode.sv]
// Address split into set index and tag from the configured field widths.
module lrucache_decode import lrucache_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic [ADDR_W-1:0] address,
  input  logic [SIB_W-1:0]  set_index_bits,
  input  logic [OFF_W-1:0]  offset_bits,
  output logic [SET_W-1:0]  set_idx,
  output logic [ADDR_W-1:0] tag
);

  logic [3:0]        ib;
  logic [ADDR_W-1:0] shifted;
  logic [SET_W-1:0]  mask;
  logic [6:0]        sh;

  always_comb begin
    ib = ({1'b0, set_index_bits} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                     : {1'b0, set_index_bits};
    shifted = address >> offset_bits;
    mask    = ~({SET_W{1'b1}} << ib);
    set_idx = shifted[SET_W-1:0] & mask;
    sh      = 7'(offset_bits) + 7'(ib);
    tag     = (sh < 7'd64) ? (address >> sh) : '0;
  end

endmodule

[hdl/lrucache_scan.sv]
// Way scanner: one shared tag comparator stepped across the ways of a set.
module lrucache_scan import lrucache_pkg::*; #(
  parameter int MAX_WAYS = 8,
  localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int WI      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int ENTRY_W = ADDR_W + RANK_W + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [WAY_IDX_W-1:0]        ways_m1,
  input  logic [MAX_WAYS*ENTRY_W-1:0] row,
  input  logic [ADDR_W-1:0]           tag,
  output logic                        done,
  output scan_res_t                   res
);

  logic [ENTRY_W-1:0]   ent [MAX_WAYS];
  logic [ENTRY_W-1:0]   cur;
  logic                 cur_valid;
  logic [RANK_W-1:0]    cur_rank;
  logic [ADDR_W-1:0]    cur_tag;
  logic                 busy;
  logic                 last;
  logic [WAY_IDX_W-1:0] cnt;
  logic [RANK_W-1:0]    vrank;

  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      ent[j] = row[j*ENTRY_W +: ENTRY_W];
    end
    cur       = ent[cnt[WI-1:0]];
    cur_valid = cur[0];
    cur_rank  = cur[RANK_W:1];
    cur_tag   = cur[ENTRY_W-1 -: ADDR_W];
    last      = (cnt == ways_m1);
    done      = busy && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt      <= '0;
      res.hit  <= 1'b0;
      res.free <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (!res.hit && cur_valid && (cur_tag == tag)) begin
        res.hit     <= 1'b1;
        res.hit_way <= cnt;
      end
      if (!res.free && !cur_valid) begin
        res.free     <= 1'b1;
        res.free_way <= cnt;
      end
      if ((cnt == '0) || (cur_rank >= vrank)) begin
        res.victim_way <= cnt;
        vrank          <= cur_rank;
      end
    end
  end

endmodule

[hdl/lru_set_assoc_cache_sim.sv]
// Top level of the tag-only set-associative cache with LRU replacement.
//
// Input stream: s_axis_tuser carries the command (load, store, modify),
// s_axis_tdata the 64-bit byte address. One result per transaction leaves on
// the m_axis stream: outcome, modify second hit and the three running totals.
// Configuration is written through cfg_we / cfg_index / cfg_data, one register
// per write, no read-back; change it only together with a reset.
//
// Each transaction steps through decode, set fetch from the set RAM, a way
// scan on the shared tag comparator (one way per cycle) and a write-back of
// the set. A new transaction is accepted only after the write-back of the
// last one; the result register is loaded in the write-back cycle.
//
// After reset the set RAM is swept clear, one set per cycle, all 2**MAX_SET_BITS
// sets, with s_axis_tready low; configuration writes are taken meanwhile.
// A pending result holds while m_axis_tready is low; a new transaction may be
// accepted then, but its write-back waits until the result is taken.
module lru_set_assoc_cache_sim import lrucache_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [63:0] address
  input  logic [CMD_W-1:0]      s_axis_tuser,  // [1:0] command
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] outcome, [2] second_hit, [34:3] hit_total, [66:35] miss_total,
  // [98:67] eviction_total, upper bits zero
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WI       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ENTRY_W  = ADDR_W + RANK_W + 1;
  localparam int ROW_W    = MAX_WAYS * ENTRY_W;

  state_t               state, state_next;
  logic [SIB_W-1:0]     set_index_bits;
  logic [WAYS_W-1:0]    ways_in_use;
  logic [OFF_W-1:0]     offset_bits;
  logic [CMD_W-1:0]     cmd;
  logic [ADDR_W-1:0]    address;
  logic [SET_W-1:0]     set_idx;
  logic [ADDR_W-1:0]    tag;
  logic [SET_W-1:0]     set_dec;
  logic [ADDR_W-1:0]    tag_dec;
  logic [SET_W-1:0]     clr_cnt;
  logic [CNT_W-1:0]     hits, misses, evictions;
  logic [CNT_W-1:0]     hits_next, misses_next, evictions_next, h1;
  logic                 out_valid;
  logic [M_TDATA_W-1:0] out_data;
  logic [WAY_IDX_W-1:0] ways_m1;
  logic                 ram_we;
  logic [SET_W-1:0]     ram_waddr;
  logic [ROW_W-1:0]     ram_wdata;
  logic [ROW_W-1:0]     row;
  logic [ROW_W-1:0]     row_new;
  logic                 scan_done;
  scan_res_t            scan_res;
  logic                 go;
  logic                 second;
  logic [OUTCOME_W-1:0] outcome;
  logic [WAY_IDX_W-1:0] w;
  logic [RANK_W-1:0]    w_rank;
  logic                 limit_all;
  logic [ENTRY_W-1:0]   ent [MAX_WAYS];
  logic [ENTRY_W-1:0]   e;
  logic                 ev;
  logic [RANK_W-1:0]    er;
  logic [ADDR_W-1:0]    et;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits <= '0;
      ways_in_use    <= WAYS_W'(1);
      offset_bits    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_INDEX_BITS: set_index_bits <= cfg_data[SIB_W-1:0];
        CFG_WAYS_IN_USE:    ways_in_use    <= cfg_data[WAYS_W-1:0];
        CFG_OFFSET_BITS:    offset_bits    <= cfg_data[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ways_in_use == '0) begin
      ways_m1 = '0;
    end else if ({1'b0, ways_in_use} > 5'(MAX_WAYS)) begin
      ways_m1 = WAY_IDX_W'(MAX_WAYS - 1);
    end else begin
      ways_m1 = ways_in_use - 1'b1;
    end
  end

  lrucache_decode #(.MAX_SET_BITS(MAX_SET_BITS)) u_decode (
    .address        (address),
    .set_index_bits (set_index_bits),
    .offset_bits    (offset_bits),
    .set_idx        (set_dec),
    .tag            (tag_dec)
  );

  lrucache_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (set_idx),
    .rdata (row)
  );

  lrucache_scan #(.MAX_WAYS(MAX_WAYS)) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (state == ST_FETCH),
    .ways_m1 (ways_m1),
    .row     (row),
    .tag     (tag),
    .done    (scan_done),
    .res     (scan_res)
  );

  // set update: chosen way becomes most recent, younger valid ways age (all valid ways on a fill)
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      ent[j] = row[j*ENTRY_W +: ENTRY_W];
    end
    w = scan_res.hit ? scan_res.hit_way
      : (scan_res.free ? scan_res.free_way : scan_res.victim_way);
    w_rank    = ent[w[WI-1:0]][RANK_W:1];
    limit_all = !scan_res.hit && scan_res.free;
    row_new   = row;
    for (int j = 0; j < MAX_WAYS; j++) begin
      e  = ent[j];
      ev = e[0];
      er = e[RANK_W:1];
      et = e[ENTRY_W-1 -: ADDR_W];
      if (WAY_IDX_W'(j) == w) begin
        row_new[j*ENTRY_W +: ENTRY_W] = {scan_res.hit ? et : tag, RANK_W'(0), 1'b1};
      end else if ((WAY_IDX_W'(j) <= ways_m1) && ev && (limit_all || (er < w_rank)) &&
                   (er < RANK_W'(MAX_WAYS - 1))) begin
        row_new[j*ENTRY_W +: ENTRY_W] = {et, er + 1'b1, ev};
      end
    end
  end

  always_comb begin
    go      = (state == ST_UPDATE) && (!out_valid || m_axis_tready);
    second  = (cmd == CMD_MODIFY);
    outcome = scan_res.hit ? OUTCOME_HIT : (scan_res.free ? OUTCOME_FILL : OUTCOME_EVICT);
    h1             = scan_res.hit ? sat_inc(hits) : hits;
    hits_next      = second ? sat_inc(h1) : h1;
    misses_next    = scan_res.hit ? misses : sat_inc(misses);
    evictions_next = (!scan_res.hit && !scan_res.free) ? sat_inc(evictions) : evictions;
    ram_we    = (state == ST_CLEAR) || go;
    ram_waddr = (state == ST_CLEAR) ? clr_cnt : set_idx;
    ram_wdata = (state == ST_CLEAR) ? '0 : row_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == SET_W'(NUM_SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd     <= s_axis_tuser;
      address <= s_axis_tdata;
    end
    if (state == ST_DECODE) begin
      set_idx <= set_dec;
      tag     <= tag_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits      <= '0;
      misses    <= '0;
      evictions <= '0;
    end else if (go) begin
      hits      <= hits_next;
      misses    <= misses_next;
      evictions <= evictions_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data <= {(M_TDATA_W - OUT_BITS)'(0), evictions_next, misses_next, hits_next,
                   second, outcome};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> hits >= $past(hits))
    else $error("hit total decreased");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_UPDATE))
    else $error("result loaded outside write-back");

  a_hit_keeps_misses: assert property (@(posedge clk) disable iff (rst)
    go && scan_res.hit |=> misses == $past(misses))
    else $error("miss counted on a hit");

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> state == ST_SCAN)
    else $error("way scan finished outside scan state");

endmodule
